FILE: src/u8sd_pkg.sv
// shared types and constants for the utf-8 stream decoder
// no dependencies; imported by every module of the block
`default_nettype none

package u8sd_pkg;

    localparam int unsigned CP_W            = 21;
    localparam int unsigned BYTE_W          = 8;
    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    // replacement character
    localparam logic [CP_W-1:0] REPL_CP = 21'h00FFFD;

    // apb register map
    localparam int unsigned APB_ADDR_W = 3;
    localparam logic        REG_IDX_UCS2_MODE = 1'b0;

    // one decode job: malformed fills before the main result, the main
    // result itself, then malformed fills for a sequence cut by string end
    typedef struct packed {
        logic [1:0]      pre_cnt;
        logic            mid_valid;
        logic            mid_bad;
        logic [CP_W-1:0] mid_cp;
        logic [1:0]      post_cnt;
        logic            fin;
    } job_t;

endpackage

`default_nettype wire

FILE: src/utf8_stream_decoder_unit.sv
// utf-8 stream decoder top level: apb config register, front end, job queue,
// result sequencer; depends on u8sd_pkg, u8sd_front, u8sd_queue, u8sd_back
// first result path: job queue slot, then the result sequencer output register
// throughput: one byte per cycle while each byte gives at most one result and
//   m_tready is high; a byte that gives more than one result holds the sequencer
// until each is sent; the job queue (QUEUE_DEPTH entries) keeps the input moving
// reset: asynchronous, active low; clears the open sequence, queue and ucs2_mode
`default_nettype none

module utf8_stream_decoder_unit
    import u8sd_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // byte stream in
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [7:0]            s_tdata,   // [7:0] byte_value
    input  wire logic                  s_tlast,   // final_byte
    // code point stream out
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [23:0]                m_tdata,   // [20:0] code_point, [23:21] zero
    output logic [1:0]                 m_tuser,   // [0] malformed, [1] run_last
    output logic                       m_tlast,   // string_end
    // configuration
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    logic            ucs2_mode_reg;
    logic            cfg_write;
    logic            s_accept;
    job_t            front_job, head_job;
    logic            front_job_valid;
    logic            queue_full;
    logic            head_valid, head_pop;
    logic [CP_W-1:0] out_cp;

    // apb: zero wait states, register index in paddr[2]
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ucs2_mode_reg <= 1'b0;
        end
        else if (cfg_write && (paddr[2] == REG_IDX_UCS2_MODE))
        begin
            ucs2_mode_reg <= pwdata[0];
        end
    end

    assign prdata = (paddr[2] == REG_IDX_UCS2_MODE) ? {31'd0, ucs2_mode_reg} : 32'd0;

    // input side stalls only when the queue has no room
    assign s_tready = !queue_full;
    assign s_accept = s_tvalid && s_tready;

    u8sd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (s_accept),
        .byte_value (s_tdata),
        .final_byte (s_tlast),
        .ucs2_mode  (ucs2_mode_reg),
        .job        (front_job),
        .job_valid  (front_job_valid)
    );

    // bytes that give no result never enter the queue
    u8sd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (front_job_valid),
        .push_job   (front_job),
        .full       (queue_full),
        .pop        (head_pop),
        .head_job   (head_job),
        .head_valid (head_valid)
    );

    u8sd_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head_job       (head_job),
        .head_valid     (head_valid),
        .pop            (head_pop),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_code_point (out_cp),
        .out_malformed  (m_tuser[0]),
        .out_run_last   (m_tuser[1]),
        .out_string_end (m_tlast)
    );

    assign m_tdata = {3'b000, out_cp};

endmodule

`default_nettype wire

FILE: src/u8sd_front.sv
// front end: tracks the open utf-8 sequence; a byte with results makes a job
// depends on u8sd_pkg
`default_nettype none

module u8sd_front
    import u8sd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic [BYTE_W-1:0] byte_value,
    input  wire logic              final_byte,
    input  wire logic              ucs2_mode,
    output job_t                   job,
    output logic                   job_valid
);

    logic [2:0]      seq_len_reg, seq_len_next;
    logic [1:0]      taken_reg, taken_next;
    logic [CP_W-1:0] partial_reg, partial_next;
    logic [CP_W-1:0] cont_value;
    logic            is_cont;
    logic            do_lead;
    logic [2:0]      total;

    assign is_cont    = (byte_value[7:6] == 2'b10);
    assign cont_value = {partial_reg[CP_W-7:0], byte_value[5:0]};

    always_comb
    begin
        seq_len_next = seq_len_reg;
        taken_next   = taken_reg;
        partial_next = partial_reg;
        job          = '0;
        do_lead      = 1'b1;

        if (seq_len_reg != 3'd0)
        begin
            if (is_cont)
            begin
                do_lead = 1'b0;
                if (({1'b0, taken_reg} + 3'd1) >= seq_len_reg)
                begin
                    job.mid_valid = 1'b1;
                    job.mid_bad   = 1'b0;
                    job.mid_cp    = (ucs2_mode && (|cont_value[CP_W-1:16])) ? REPL_CP
                                                                          : cont_value;
                    seq_len_next  = 3'd0;
                    taken_next    = 2'd0;
                    partial_next  = '0;
                end
                else
                begin
                    partial_next = cont_value;
                    taken_next   = taken_reg + 2'd1;
                end
            end
            else
            begin
                // bad continuation: flush what was taken, then retry as lead
                job.pre_cnt  = taken_reg;
                seq_len_next = 3'd0;
                taken_next   = 2'd0;
                partial_next = '0;
            end
        end

        if (do_lead)
        begin
            if (!byte_value[7])
            begin
                job.mid_valid = 1'b1;
                job.mid_cp    = {{(CP_W-BYTE_W){1'b0}}, byte_value};
            end
            else if (byte_value[7:5] == 3'b110)
            begin
                seq_len_next = 3'd2;
                taken_next   = 2'd1;
                partial_next = {{(CP_W-5){1'b0}}, byte_value[4:0]};
            end
            else if (byte_value[7:4] == 4'b1110)
            begin
                seq_len_next = 3'd3;
                taken_next   = 2'd1;
                partial_next = {{(CP_W-4){1'b0}}, byte_value[3:0]};
            end
            else if (byte_value[7:3] == 5'b11110)
            begin
                seq_len_next = 3'd4;
                taken_next   = 2'd1;
                partial_next = {{(CP_W-3){1'b0}}, byte_value[2:0]};
            end
            else
            begin
                job.mid_valid = 1'b1;
                job.mid_bad   = 1'b1;
                job.mid_cp    = REPL_CP;
            end
        end

        // string ends inside a sequence
        if (final_byte && (seq_len_next != 3'd0))
        begin
            job.post_cnt = taken_next;
            seq_len_next = 3'd0;
            taken_next   = 2'd0;
            partial_next = '0;
        end

        job.fin = final_byte;
    end

    assign total     = {1'b0, job.pre_cnt} + {2'b00, job.mid_valid} + {1'b0, job.post_cnt};
    assign job_valid = accept && (total != 3'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_len_reg <= 3'd0;
            taken_reg   <= 2'd0;
            partial_reg <= '0;
        end
        else if (accept)
        begin
            seq_len_reg <= seq_len_next;
            taken_reg   <= taken_next;
            partial_reg <= partial_next;
        end
    end

`ifndef SYNTH
    a_final_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && final_byte) |=> (seq_len_reg == 3'd0))
        else $error("sequence still open after final byte");
`endif

endmodule

`default_nettype wire

FILE: src/u8sd_queue.sv
// short job queue between front end and result sequencer
// depends on u8sd_pkg
`default_nettype none

module u8sd_queue
    import u8sd_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire job_t push_job,
    output logic      full,
    input  wire logic pop,
    output job_t      head_job,
    output logic      head_valid
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    job_t             slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = slots_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");
`endif

endmodule

`default_nettype wire

FILE: src/u8sd_back.sv
// result sequencer: expands each job into code points, one per cycle
// unless out_ready stalls the output; depends on u8sd_pkg
`default_nettype none

module u8sd_back
    import u8sd_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire job_t             head_job,
    input  wire logic             head_valid,
    output logic                  pop,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [CP_W-1:0]       out_code_point,
    output logic                  out_malformed,
    output logic                  out_run_last,
    output logic                  out_string_end
);

    logic [1:0]      emit_cnt_reg;
    logic            out_valid_reg;
    logic [CP_W-1:0] cp_reg;
    logic            bad_reg, run_last_reg, string_end_reg;
    logic [2:0]      total;
    logic            advance, is_last, is_mid;

    assign total   = {1'b0, head_job.pre_cnt} + {2'b00, head_job.mid_valid}
                   + {1'b0, head_job.post_cnt};
    assign advance = head_valid && (!out_valid_reg || out_ready);
    assign is_last = (({1'b0, emit_cnt_reg} + 3'd1) == total);
    assign is_mid  = head_job.mid_valid && (emit_cnt_reg == head_job.pre_cnt);
    assign pop     = advance && is_last;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            cp_reg         <= is_mid ? head_job.mid_cp : REPL_CP;
            bad_reg        <= is_mid ? head_job.mid_bad : 1'b1;
            run_last_reg   <= is_last;
            string_end_reg <= is_last && head_job.fin;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emit_cnt_reg  <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                emit_cnt_reg  <= is_last ? 2'd0 : emit_cnt_reg + 2'd1;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_code_point = cp_reg;
    assign out_malformed  = bad_reg;
    assign out_run_last   = run_last_reg;
    assign out_string_end = string_end_reg;

`ifndef SYNTH
    a_cnt_in_job: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> ({1'b0, emit_cnt_reg} < total))
        else $error("emit count past end of job");
    a_end_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && string_end_reg) |-> run_last_reg)
        else $error("string end on a result that is not last of its byte");
`endif

endmodule

`default_nettype wire
